// File: src/fwrt_pkg.sv
// Package for the firewall rule table: command and status codes and the
// rule and slot entry types. Depends on nothing.
`timescale 1ns / 1ps
package fwrt_pkg;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_low;
    logic [ADDR_W-1:0] addr_high;
    logic [PORT_W-1:0] port_low;
    logic [PORT_W-1:0] port_high;
  } rule_t;

  // One slot of the rule memory: the valid flag travels with the bounds.
  typedef struct packed {
    logic  valid;
    rule_t rule;
  } entry_t;

  // Result of comparing one stored slot against the item under test.
  typedef struct packed {
    logic hit;
    logic slot_valid;
  } match_t;

endpackage

// File: src/fwrt_if.sv
// Valid/ready channel interfaces for the firewall rule table items.
// Depends on fwrt_pkg for the field widths.
`timescale 1ns / 1ps
interface fwrt_in_if;
  import fwrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr_low;
  logic [ADDR_W-1:0] addr_high;
  logic [PORT_W-1:0] port_low;
  logic [PORT_W-1:0] port_high;

  modport source (output valid, cmd, addr_low, addr_high, port_low, port_high,
                  input ready);
  modport sink (input valid, cmd, addr_low, addr_high, port_low, port_high,
                output ready);
endinterface

interface fwrt_out_if;
  import fwrt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  rule_count;

  modport source (output valid, status, rule_count, input ready);
  modport sink (input valid, status, rule_count, output ready);
endinterface

// File: src/fwrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module fwrt_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fwrt_match.sv
// Slot comparator: decides whether one stored slot satisfies the current
// command (free slot for add, exact match for delete, cover for check).
// Depends on fwrt_pkg.
`timescale 1ns / 1ps
module fwrt_match (
  input  logic [fwrt_pkg::CMD_W-1:0] cmd,
  input  fwrt_pkg::rule_t            item,
  input  fwrt_pkg::entry_t           entry,
  output fwrt_pkg::match_t           result
);
  import fwrt_pkg::*;

  logic exact;
  logic covers;

  assign exact = (entry.rule == item);
  assign covers = (item.addr_low >= entry.rule.addr_low) &&
                  (item.addr_low <= entry.rule.addr_high) &&
                  (item.port_low >= entry.rule.port_low) &&
                  (item.port_low <= entry.rule.port_high);

  always_comb begin
    result.slot_valid = entry.valid;
    case (cmd)
      CMD_ADD:    result.hit = !entry.valid;
      CMD_DELETE: result.hit = entry.valid && exact;
      CMD_CHECK:  result.hit = entry.valid && covers;
      default:    result.hit = 1'b0;
    endcase
  end

endmodule

// File: src/firewall_rule_table.sv
// Top level of the firewall rule table: scan sequencer around the rule memory.
// Depends on fwrt_pkg, fwrt_if, fwrt_ram and fwrt_match.
`timescale 1ns / 1ps
// The block holds RULE_SLOTS IPv4 filter rules, each an address range and a
// port range. Items arrive on in_ch (valid/ready) and carry a command: add a
// rule, delete a rule, or check an address and port. Each item produces
// exactly one result item on out_ch with a status code and the number of
// valid rules after the item.
// Every rule lives in one synchronous memory together with its valid flag.
// An accepted item starts a scan that reads one slot per cycle from slot 0
// upward; the comparison runs on the registered read data in the next cycle.
// The scan stops at the first slot that satisfies the command: a free slot
// for add, an exact match for delete, a covering rule for check. Add and
// delete write that slot back in the cycle the hit is seen.
// An item with an invalid command, or with a reversed range on add or
// delete, skips the scan; for the others the time an item takes is set by
// the single memory read port walking the slots. One item is in work at a time.
// The result sits in an output register; the next item is accepted as soon
// as the scan is done, even while that result waits to be taken. If the
// receiver stalls with a result still pending, the next finished result
// waits in the block and no further item is accepted.
// After a reset the block runs a clearing pass over all RULE_SLOTS memory
// slots and accepts no item until it is done.
module firewall_rule_table #(
  parameter int RULE_SLOTS = 64
) (
  input logic      clk,
  input logic      rst_n,
  fwrt_in_if.sink  in_ch,
  fwrt_out_if.source out_ch
);
  import fwrt_pkg::*;

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W = $clog2(RULE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(RULE_SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  rule_t               item_r, item_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  match_t           match;

  logic                 in_fire;
  logic                 reversed;
  logic                 out_free;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  fwrt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(RULE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue_r),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  fwrt_match u_match (
    .cmd   (cmd_r),
    .item  (item_r),
    .entry (ram_rdata),
    .result(match)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign reversed    = (in_ch.addr_low > in_ch.addr_high) ||
                       (in_ch.port_low > in_ch.port_high);
  assign out_free    = !out_valid_r || out_ch.ready;

  // The count is reported modulo 128, whatever the counter width.
  assign count_ext = {{COUNT_W{1'b0}}, total_r};

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.rule_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    issue_nxt      = 1'b0;
    pend_v_nxt     = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    total_nxt      = total_r;
    cmd_nxt        = cmd_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    ram_wdata      = '{valid: 1'b0, rule: item_r};

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_ch.cmd;
          item_nxt = '{addr_low: in_ch.addr_low, addr_high: in_ch.addr_high,
                       port_low: in_ch.port_low, port_high: in_ch.port_high};
          if ((in_ch.cmd == CMD_CHECK) ||
              (((in_ch.cmd == CMD_ADD) || (in_ch.cmd == CMD_DELETE)) && !reversed)) begin
            rd_idx_nxt = '0;
            issue_nxt  = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // Keep issuing reads until the last slot has been requested.
        if (issue_r) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            issue_nxt  = 1'b1;
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (pend_v_r && match.hit) begin
          // First qualifying slot: act on it and drop reads in flight.
          issue_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_DONE;
          case (cmd_r)
            CMD_ADD: begin
              ram_we         = 1'b1;
              ram_wdata      = '{valid: 1'b1, rule: item_r};
              total_nxt      = total_r + 1'b1;
              res_status_nxt = ST_ADDED;
            end
            CMD_DELETE: begin
              ram_we         = 1'b1;
              ram_wdata      = '{valid: 1'b0, rule: item_r};
              if (total_r != '0) begin
                total_nxt = total_r - 1'b1;
              end
              res_status_nxt = ST_DELETED;
            end
            default: begin
              res_status_nxt = ST_ACCEPTED;
            end
          endcase
        end else if (pend_v_r && (pend_idx_r == LAST_IDX)) begin
          issue_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_DONE;
          case (cmd_r)
            CMD_ADD:    res_status_nxt = ST_FULL;
            CMD_DELETE: res_status_nxt = ST_NOTFOUND;
            default:    res_status_nxt = ST_REJECTED;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      issue_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      issue_r     <= issue_nxt;
      pend_v_r    <= pend_v_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    cmd_r        <= cmd_nxt;
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The rule count can never pass the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_MAX)
    else $error("rule count exceeds table size");

  // Read data is only compared while a scan is running.
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_SCAN))
    else $error("slot compare outside a scan");

  // A successful add raises the count by exactly one.
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_v_r && match.hit && cmd_r == CMD_ADD)
      |=> (total_r == $past(total_r) + 1'b1) && (state_r == S_DONE))
    else $error("add did not update the rule count");

  // No item is taken while the clearing pass is still running.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("input ready during clearing pass");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for firewall_rule_table: add, delete and check items
// against a predictor of the rule slots. Depends on fwrt_pkg, fwrt_if and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import fwrt_pkg::*;

  localparam int SLOTS = 64;
  // Upper bound on the run.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1600;
  // Command code 3 has no name in the package. The block must reject it.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    rule_t            rule;
    // The sender holds this item back until every earlier result has come.
    bit               drain;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } verdict_t;

  logic clk;
  logic rst_n;

  fwrt_in_if  in_ch ();
  fwrt_out_if out_ch ();

  firewall_rule_table #(
    .RULE_SLOTS(SLOTS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Items waiting to be sent, and the verdicts still owed by the block.
  request_t pending[$];
  verdict_t owed_verdicts[$];

  // Rules that the stimulus expects to be in the table. The generator uses
  // them to aim deletes and checks at real rules. It does not take part in
  // checking.
  rule_t planned_rules[$];

  // Predictor state: one copy of the rule memory and its count.
  bit    slot_used[SLOTS];
  rule_t slot_rule[SLOTS];
  int    used_total;

  bit       in_fire;
  int       sent_count;
  int       send_gap;
  int       stall_gap;
  int       errors;
  int       cycles;
  int       status_tally[7];
  request_t next_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_reversed(rule_t r);
    return (r.addr_low > r.addr_high) || (r.port_low > r.port_high);
  endfunction

  // Works out the status and rule count that one accepted item must produce,
  // and updates the predicted table the same way the block should.
  function automatic verdict_t predict_verdict(request_t r);
    verdict_t v;
    bit       found;
    found = 1'b0;
    case (r.cmd)
      CMD_ADD: begin
        if (is_reversed(r.rule)) begin
          v.status = ST_INVALID;
        end else begin
          // The lowest free slot takes the rule. Equal rules are not merged.
          v.status = ST_FULL;
          for (int k = 0; k < SLOTS && !found; k++) begin
            if (!slot_used[k]) begin
              slot_used[k] = 1'b1;
              slot_rule[k] = r.rule;
              used_total++;
              v.status = ST_ADDED;
              found = 1'b1;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (is_reversed(r.rule)) begin
          v.status = ST_INVALID;
        end else begin
          // Only an exact match on all four bounds counts. A single address
          // therefore never removes a range, and the reverse is also true.
          v.status = ST_NOTFOUND;
          for (int k = 0; k < SLOTS && !found; k++) begin
            if (slot_used[k] && slot_rule[k] == r.rule) begin
              slot_used[k] = 1'b0;
              if (used_total > 0) used_total--;
              v.status = ST_DELETED;
              found = 1'b1;
            end
          end
        end
      end
      CMD_CHECK: begin
        // The high bounds of a check item are ignored. The address is
        // compared as one 32-bit number, not octet by octet.
        v.status = ST_REJECTED;
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_used[k] &&
              r.rule.addr_low >= slot_rule[k].addr_low &&
              r.rule.addr_low <= slot_rule[k].addr_high &&
              r.rule.port_low >= slot_rule[k].port_low &&
              r.rule.port_low <= slot_rule[k].port_high)
            v.status = ST_ACCEPTED;
        end
      end
      default: begin
        v.status = ST_INVALID;
      end
    endcase
    v.count = used_total[COUNT_W-1:0];
    return v;
  endfunction

  // Appends an item and keeps the planned view of the table up to date.
  function automatic void queue_item(request_t r);
    bit gone;
    gone = 1'b0;
    pending.push_back(r);
    if (is_reversed(r.rule)) return;
    if (r.cmd == CMD_ADD && planned_rules.size() < SLOTS) begin
      planned_rules.push_back(r.rule);
    end else if (r.cmd == CMD_DELETE) begin
      for (int k = 0; k < planned_rules.size() && !gone; k++) begin
        if (planned_rules[k] == r.rule) begin
          planned_rules.delete(k);
          gone = 1'b1;
        end
      end
    end
  endfunction

  function automatic request_t mk(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] al,
                                  logic [ADDR_W-1:0] ah, logic [PORT_W-1:0] pl,
                                  logic [PORT_W-1:0] ph);
    request_t r;
    r.cmd = cmd;
    r.rule.addr_low = al;
    r.rule.addr_high = ah;
    r.rule.port_low = pl;
    r.rule.port_high = ph;
    r.drain = 1'b0;
    return r;
  endfunction

  // Adds a span to a low bound and stops at the top of the range.
  function automatic logic [ADDR_W-1:0] clip_end(logic [ADDR_W-1:0] lo,
                                                 logic [ADDR_W-1:0] span);
    if (span > 32'hFFFF_FFFF - lo) return 32'hFFFF_FFFF;
    return lo + span;
  endfunction

  // Half of the addresses and ports fall in a narrow region so that rules
  // overlap and checks hit. The extremes and fully random values are mixed in.
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      default: return 32'h0A00_0000 + $urandom_range(0, 8191);
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic rule_t pick_rule();
    rule_t            r;
    logic [ADDR_W-1:0] span;
    logic [PORT_W-1:0] pspan;
    r.addr_low = pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2: span = 0;
      3, 4, 5, 6: span = $urandom_range(1, 300);
      7, 8: span = $urandom_range(0, 1 << 20);
      default: span = $urandom;
    endcase
    r.addr_high = clip_end(r.addr_low, span);
    r.port_low = pick_port();
    case ($urandom_range(0, 9))
      0, 1, 2: pspan = 0;
      3, 4, 5, 6, 7: pspan = $urandom_range(1, 200);
      default: pspan = 16'($urandom);
    endcase
    if (pspan > 16'hFFFF - r.port_low) r.port_high = 16'hFFFF;
    else r.port_high = r.port_low + pspan;
    return r;
  endfunction

  // Builds one random item. The phase shifts the mix between adds and
  // deletes, so that the table fills to the limit and then drains again.
  function automatic request_t pick_request(int phase);
    request_t         r;
    rule_t            p;
    int               roll;
    int               add_pct;
    int               del_pct;
    logic [63:0]      off;
    logic [ADDR_W-1:0] x;
    logic [ADDR_W-1:0] y;
    r.drain = 1'b0;
    r.rule = pick_rule();
    roll = $urandom_range(0, 99);
    add_pct = (phase == 1) ? 65 : (phase == 2) ? 20 : 35;
    del_pct = (phase == 2) ? 50 : 25;
    if (roll < 2) begin
      r.cmd = CMD_UNKNOWN;
      r.rule = {$urandom, $urandom, $urandom};
    end else if (roll < 2 + add_pct) begin
      r.cmd = CMD_ADD;
    end else if (roll < 2 + add_pct + del_pct) begin
      r.cmd = CMD_DELETE;
      if (planned_rules.size() > 0 && $urandom_range(0, 9) < 7) begin
        r.rule = planned_rules[$urandom_range(0, planned_rules.size() - 1)];
        // A near miss: one bound off by a single bit.
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: r.rule.addr_low ^= 32'd1 << $urandom_range(0, 31);
            1: r.rule.addr_high ^= 32'd1 << $urandom_range(0, 31);
            2: r.rule.port_low ^= 16'd1 << $urandom_range(0, 15);
            default: r.rule.port_high ^= 16'd1 << $urandom_range(0, 15);
          endcase
        end
      end
    end else begin
      r.cmd = CMD_CHECK;
      if (planned_rules.size() > 0 && $urandom_range(0, 9) < 7) begin
        // Aim at a point inside a stored rule.
        p = planned_rules[$urandom_range(0, planned_rules.size() - 1)];
        off = {$urandom, $urandom} % (64'(p.addr_high - p.addr_low) + 64'd1);
        r.rule.addr_low = p.addr_low + off[31:0];
        off = {$urandom, $urandom} % (64'(p.port_high - p.port_low) + 64'd1);
        r.rule.port_low = p.port_low + off[15:0];
      end
      r.rule.addr_high = $urandom;
      r.rule.port_high = 16'($urandom);
    end
    // Some adds and deletes get a reversed range.
    if ((r.cmd == CMD_ADD || r.cmd == CMD_DELETE) && $urandom_range(0, 24) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        x = $urandom;
        y = $urandom;
        if (x == y) y = x ^ 32'd1;
        r.rule.addr_low = (x > y) ? x : y;
        r.rule.addr_high = (x > y) ? y : x;
      end else begin
        x = $urandom_range(1, 65535);
        r.rule.port_low = x[15:0];
        r.rule.port_high = 16'($urandom_range(0, x - 1));
      end
    end
    return r;
  endfunction

  // Both sides may idle, except in every fifth stretch of 100 items and in
  // the last part of the run.
  function automatic bit idle_ok();
    return pending.size() > 150 && (sent_count / 100) % 5 != 4;
  endfunction

  // Driver and receiver. The inputs change on the falling edge, away from
  // the rising edge where the block samples them.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      // An item stays on the channel until the block accepts it.
      if (!in_ch.valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending.size() == 0 ||
                     (pending[0].drain && owed_verdicts.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else if (idle_ok() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_ch.valid <= 1'b0;
        end else begin
          next_req = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= next_req.cmd;
          in_ch.addr_low <= next_req.rule.addr_low;
          in_ch.addr_high <= next_req.rule.addr_high;
          in_ch.port_low <= next_req.rule.port_low;
          in_ch.port_high <= next_req.rule.port_high;
          sent_count++;
        end
      end
      // The receiver stalls in bursts of random length.
      if (stall_gap > 0) begin
        stall_gap = stall_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
        stall_gap = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor. At each rising edge an accepted input item is predicted, and an
  // accepted result is compared with the oldest verdict still owed.
  always @(posedge clk) begin
    verdict_t want;
    request_t seen;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      seen.cmd = in_ch.cmd;
      seen.rule.addr_low = in_ch.addr_low;
      seen.rule.addr_high = in_ch.addr_high;
      seen.rule.port_low = in_ch.port_low;
      seen.rule.port_high = in_ch.port_high;
      seen.drain = 1'b0;
      owed_verdicts.push_back(predict_verdict(seen));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.status <= ST_INVALID) status_tally[out_ch.status]++;
      if (owed_verdicts.size() == 0) begin
        $error("unexpected result: status %0d, rule_count %0d",
               out_ch.status, out_ch.rule_count);
        errors++;
      end else begin
        want = owed_verdicts.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.rule_count !== want.count) begin
          $error("rule_count mismatch: expected %0d, actual %0d",
                 want.count, out_ch.rule_count);
          errors++;
        end
      end
    end
  end

  // Watchdog. It ends a run that hangs.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("firewall_rule_table test failed");
    $finish;
  end

  initial begin
    request_t r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.addr_low = '0;
    in_ch.addr_high = '0;
    in_ch.port_low = '0;
    in_ch.port_high = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    sent_count = 0;
    send_gap = 0;
    stall_gap = 0;
    errors = 0;
    used_total = 0;
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    foreach (status_tally[k]) status_tally[k] = 0;

    // Directed items. They start on an empty table, use the widest possible
    // rule, test a single address with a single port and the edges around
    // it, a duplicate rule, a range that crosses an octet boundary, reversed
    // ranges, check items whose high bounds are ignored, an unknown command,
    // and a delete whose port range differs from the stored rule.
    queue_item(mk(CMD_CHECK, 32'h0A00_0001, 32'h0A00_0001, 16'd80, 16'd80));
    queue_item(mk(CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF));
    queue_item(mk(CMD_CHECK, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0));
    queue_item(mk(CMD_CHECK, 32'h0000_0000, 32'h0, 16'h0000, 16'h0));
    queue_item(mk(CMD_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF));
    queue_item(mk(CMD_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF));
    queue_item(mk(CMD_ADD, 32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80));
    queue_item(mk(CMD_CHECK, 32'hC0A8_0001, 32'h0, 16'd80, 16'd0));
    queue_item(mk(CMD_CHECK, 32'hC0A8_0001, 32'h0, 16'd81, 16'd0));
    queue_item(mk(CMD_CHECK, 32'hC0A8_0002, 32'h0, 16'd80, 16'd0));
    queue_item(mk(CMD_ADD, 32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80));
    queue_item(mk(CMD_DELETE, 32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80));
    queue_item(mk(CMD_CHECK, 32'hC0A8_0001, 32'h0, 16'd80, 16'd0));
    queue_item(mk(CMD_ADD, 32'h0A00_FF00, 32'h0A01_000A, 16'd1000, 16'd2000));
    queue_item(mk(CMD_CHECK, 32'h0A00_FFC8, 32'h0, 16'd1500, 16'd0));
    queue_item(mk(CMD_CHECK, 32'h0A01_000B, 32'h0, 16'd1500, 16'd0));
    queue_item(mk(CMD_CHECK, 32'h0A01_000A, 32'h0, 16'd2000, 16'd0));
    queue_item(mk(CMD_CHECK, 32'h0A00_FF00, 32'h0, 16'd999, 16'd0));
    queue_item(mk(CMD_ADD, 32'h0A00_0010, 32'h0A00_000F, 16'd1, 16'd2));
    queue_item(mk(CMD_ADD, 32'h0A00_0010, 32'h0A00_0010, 16'd80, 16'd79));
    queue_item(mk(CMD_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000));
    queue_item(mk(CMD_CHECK, 32'h0A00_FF80, 32'h0, 16'd1500, 16'd0));
    queue_item(mk(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    queue_item(mk(CMD_DELETE, 32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd81));
    queue_item(mk(CMD_DELETE, 32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80));

    // Random part, in phases of 200 items. The first item of each phase
    // waits until the block has answered everything before it.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = pick_request((n / 200) % 3);
      r.drain = (n % 200 == 0);
      queue_item(r);
    end

    // Reset is released on a falling edge. The block then clears its memory before
    // it accepts the first item, and the driver simply waits for ready.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_ch.valid || owed_verdicts.size() != 0)
      @(posedge clk);
    // Any stray result would have to turn up within one scan.
    repeat (SLOTS + 16) @(posedge clk);

    $display("Covered %0d items in %0d cycles: added %0d, full %0d, deleted %0d,",
             sent_count, cycles, status_tally[ST_ADDED], status_tally[ST_FULL],
             status_tally[ST_DELETED]);
    $display("  not found %0d, accepted %0d, rejected %0d, invalid %0d, mismatches %0d",
             status_tally[ST_NOTFOUND], status_tally[ST_ACCEPTED],
             status_tally[ST_REJECTED], status_tally[ST_INVALID], errors);
    if (errors == 0) begin
      $display("firewall_rule_table test passed");
    end else begin
      $display("firewall_rule_table test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/fwrt_pkg.sv
src/fwrt_if.sv
src/fwrt_ram.sv
src/fwrt_match.sv
src/firewall_rule_table.sv
tb/tb_top.sv
